@@ rtl/dll_pkg.sv @@
// Package with command, status, payload and state types of the linked list engine.
`default_nettype none
package dll_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned LinkW = AddrW + 1;
  localparam int unsigned CmdW = 4;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_INSERT     = 4'd2,
    CMD_POP_FRONT  = 4'd3,
    CMD_POP_BACK   = 4'd4,
    CMD_ERASE      = 4'd5,
    CMD_CHECK      = 4'd6,
    CMD_REMOVE_ONE = 4'd7,
    CMD_REMOVE_ALL = 4'd8,
    CMD_CLEAR      = 4'd9
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                        cmd;
    logic signed [DataWidth-1:0] value;
    logic [LinkW-1:0]            handle;
  } list_cmd_t;

  typedef struct packed {
    status_e          status;
    logic             found;
    logic [AddrW-1:0] new_handle;
    logic [LinkW-1:0] removed_count;
    logic [LinkW-1:0] length;
  } list_rsp_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_FIND   = 10'b0000000010,
    S_RD     = 10'b0000000100,
    S_WAIT   = 10'b0000001000,
    S_LINK   = 10'b0000010000,
    S_ULINK  = 10'b0000100000,
    S_SCAN   = 10'b0001000000,
    S_SCANW  = 10'b0010000000,
    S_SCANC  = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_e;
endpackage
`default_nettype wire

@@ rtl/dll_stream_if.sv @@
// Valid/ready channel interface with a generic payload.
`default_nettype none
interface dll_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/doubly_linked_list_engine_unit.sv @@
// Top level of the doubly linked list engine with its command sequencer.
//
// Channel | Dir | Payload
// cmd_i   | in  | cmd, value, handle
// rsp_o   | out | status, found, new_handle, removed_count, length
//
// Commands that touch no node give the result in the cycle after the transfer. Inserts
// scan the in-use bits from slot zero one per cycle to find the lowest free slot. Check
// and removals walk the list node by node through the shared node memory read port, and
// unlink each removed node on the way. Reset empties the list at once. Ready is low while a
// command is in flight and while a result waits to be taken.
`default_nettype none
module doubly_linked_list_engine_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  dll_stream_if.sink   cmd_i,
  dll_stream_if.source rsp_o
);
  import dll_pkg::*;
  localparam int unsigned CAPACITY   = Capacity;
  localparam int unsigned DATA_WIDTH = DataWidth;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = AW + 1;
  localparam logic [LW-1:0] Sent = LW'(CAPACITY);

  state_e state_q, state_d;
  logic [CAPACITY-1:0] used_q, used_d;
  logic [LW-1:0] first_q, first_d, last_q, last_d, count_q, count_d;
  logic [3:0] cmd_q, cmd_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [LW-1:0] h_q, h_d, cur_q, cur_d, p_q, p_d, q_q, q_d, k_q, k_d;
  logic [AW-1:0] slot_q, slot_d;
  status_e st_q, st_d;
  logic found_q, found_d, done_q, done_d, wsel_q, wsel_d;
  logic [LW-1:0] rem_q, rem_d;

  // Node memory: value, next, prev in one word.
  localparam int unsigned NW = DATA_WIDTH + 2 * LW;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [NW-1:0] wdata, rdata;
  dll_ram #(.Width(NW), .Depth(CAPACITY)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );
  logic [DATA_WIDTH-1:0] r_val;
  logic [LW-1:0] r_nx, r_pv;
  assign {r_val, r_nx, r_pv} = rdata;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = (state_q == S_OUT);
  assign rsp_o.payload.status = st_q;
  assign rsp_o.payload.found = found_q;
  assign rsp_o.payload.new_handle = slot_q;
  assign rsp_o.payload.removed_count = rem_q;
  assign rsp_o.payload.length = count_q;

  function automatic logic is_node(logic [LW-1:0] n, logic [CAPACITY-1:0] u);
    return (n < Sent) && u[n[AW-1:0]];
  endfunction

  // Link fix sequence, shared by insert and unlink: ops are set_nx(p,x) and set_pv(q,y).
  // A micro-step reads node p, writes its next; then reads q, writes its prev.
  logic [1:0] ph_q, ph_d;
  logic [LW-1:0] nxv_q, nxv_d, pvv_q, pvv_d;

  always_comb begin
    state_d = state_q; used_d = used_q; first_d = first_q; last_d = last_q;
    count_d = count_q; cmd_d = cmd_q; val_d = val_q; h_d = h_q; cur_d = cur_q;
    p_d = p_q; q_d = q_q; k_d = k_q; slot_d = slot_q; st_d = st_q; found_d = found_q;
    done_d = done_q; wsel_d = wsel_q; rem_d = rem_q;
    ph_d = ph_q; nxv_d = nxv_q; pvv_d = pvv_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = cur_q[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d = cmd_i.payload.cmd; val_d = cmd_i.payload.value;
          h_d = LW'(cmd_i.payload.handle);
          st_d = ST_OK; found_d = 1'b0; slot_d = '0; rem_d = '0; k_d = '0;
          state_d = S_OUT;
          case (cmd_i.payload.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
              if (cmd_i.payload.cmd == CMD_INSERT &&
                  !(LW'(cmd_i.payload.handle) == Sent ||
                    is_node(LW'(cmd_i.payload.handle), used_q))) begin
                st_d = ST_BAD;
              end else if (&used_q) begin
                st_d = ST_FULL;
              end else begin
                if (cmd_i.payload.cmd == CMD_PUSH_FRONT) h_d = first_q;
                else if (cmd_i.payload.cmd == CMD_PUSH_BACK) h_d = Sent;
                state_d = S_FIND;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (count_q == '0) st_d = ST_EMPTY;
              else begin
                cur_d = (cmd_i.payload.cmd == CMD_POP_FRONT) ? first_q : last_q;
                rem_d = LW'(1);
                state_d = S_RD;
              end
            end
            CMD_ERASE: begin
              if (!(LW'(cmd_i.payload.handle) == Sent ||
                    is_node(LW'(cmd_i.payload.handle), used_q))) st_d = ST_BAD;
              else if (LW'(cmd_i.payload.handle) == Sent) begin
                if (first_q == Sent) st_d = ST_EMPTY;
                else begin
                  cur_d = first_q; rem_d = LW'(1); state_d = S_RD;
                end
              end else begin
                // Read the handle's node to learn its successor.
                cur_d = LW'(cmd_i.payload.handle); wsel_d = 1'b1; state_d = S_RD;
              end
            end
            CMD_CHECK, CMD_REMOVE_ONE, CMD_REMOVE_ALL: begin
              cur_d = first_q;
              state_d = (first_q == Sent) ? S_SCANC : S_SCAN;
            end
            CMD_CLEAR: begin
              rem_d = count_q; used_d = '0; first_d = Sent; last_d = Sent; count_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_FIND: begin
        if (!used_q[k_q[AW-1:0]]) begin
          slot_d = k_q[AW-1:0];
          // p = pv(h)
          if (h_q == Sent) begin
            p_d = last_q; state_d = S_LINK;
          end else begin
            cur_d = h_q; state_d = S_RD;
          end
        end else k_d = k_q + 1'b1;
      end
      S_RD: state_d = S_WAIT;
      S_WAIT: begin
        if (cmd_q == CMD_ERASE && wsel_q) begin
          wsel_d = 1'b0;
          if (r_nx == Sent) begin st_d = ST_EMPTY; state_d = S_OUT; end
          else begin cur_d = r_nx; rem_d = LW'(1); state_d = S_RD; end
        end else if (cmd_q <= CMD_INSERT) begin
          p_d = r_pv; state_d = S_LINK;
        end else begin
          // Unlink cur: p = prev, q = next.
          p_d = r_pv; q_d = r_nx;
          nxv_d = r_nx; pvv_d = r_pv; ph_d = 2'd0;
          used_d[cur_q[AW-1:0]] = 1'b0;
          if (count_q != '0) count_d = count_q - 1'b1;
          state_d = S_ULINK;
        end
      end
      S_LINK: begin
        // Write the new node, then fix p.next and h.prev.
        we = 1'b1; waddr = slot_q; wdata = {val_q, h_q, p_q};
        used_d[slot_q] = 1'b1; count_d = count_q + 1'b1;
        q_d = h_q; nxv_d = LW'(slot_q); pvv_d = LW'(slot_q); ph_d = 2'd0;
        state_d = S_ULINK;
      end
      S_ULINK: begin
        // ph 0: read p; 1: write p.next; 2: read q; 3: wait, write q.prev.
        case (ph_q)
          2'd0: begin
            if (p_q == Sent) begin first_d = nxv_q; ph_d = 2'd2; end
            else begin raddr = p_q[AW-1:0]; ph_d = 2'd1; end
          end
          2'd1: begin
            we = 1'b1; waddr = p_q[AW-1:0];
            wdata = {r_val, nxv_q, r_pv};
            ph_d = 2'd2;
          end
          2'd2: begin
            if (q_q == Sent) begin
              last_d = pvv_q;
              state_d = (cmd_q >= CMD_CHECK) ? S_SCANC : S_OUT;
            end else begin raddr = q_q[AW-1:0]; ph_d = 2'd3; end
          end
          default: begin
            // read issued last cycle with ph 2; data valid now
            if (!done_q) done_d = 1'b1;
            else begin
              done_d = 1'b0;
              we = 1'b1; waddr = q_q[AW-1:0];
              wdata = {r_val, r_nx, pvv_q};
              state_d = (cmd_q >= CMD_CHECK) ? S_SCANC : S_OUT;
            end
            raddr = q_q[AW-1:0];
          end
        endcase
      end
      S_SCAN: state_d = S_SCANW;
      S_SCANW: begin
        k_d = k_q + 1'b1;
        if (r_val == val_q) begin
          found_d = 1'b1;
          if (cmd_q == CMD_CHECK) state_d = S_SCANC;
          else begin
            rem_d = rem_q + 1'b1;
            if (cmd_q == CMD_REMOVE_ONE) k_d = Sent;
            p_d = r_pv; q_d = r_nx; nxv_d = r_nx; pvv_d = r_pv; ph_d = 2'd0;
            used_d[cur_q[AW-1:0]] = 1'b0;
            if (count_q != '0) count_d = count_q - 1'b1;
            cur_d = r_nx;
            state_d = S_ULINK;
          end
        end else begin
          cur_d = r_nx; state_d = S_SCANC;
        end
      end
      S_SCANC: begin
        if (cmd_q == CMD_CHECK && found_q) state_d = S_OUT;
        else if (cur_q >= Sent || k_q >= Sent) state_d = S_OUT;
        else state_d = S_SCAN;
        if (state_d == S_OUT && cmd_q != CMD_CHECK) begin
          found_d = 1'b0;
          if (rem_q == '0) st_d = ST_EMPTY;
        end
      end
      S_OUT: if (rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; used_q <= '0; first_q <= Sent; last_q <= Sent;
      count_q <= '0; done_q <= 1'b0; ph_q <= '0; wsel_q <= 1'b0;
    end else begin
      state_q <= state_d; used_q <= used_d; first_q <= first_d; last_q <= last_d;
      count_q <= count_d; done_q <= done_d; ph_q <= ph_d; wsel_q <= wsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; val_q <= val_d; h_q <= h_d; cur_q <= cur_d; p_q <= p_d;
    q_q <= q_d; k_q <= k_d; slot_q <= slot_d; st_q <= st_d; found_q <= found_d;
    rem_q <= rem_d; nxv_q <= nxv_d; pvv_q <= pvv_d;
  end
endmodule
`default_nettype wire

@@ rtl/dll_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module dll_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
